[rtl/core/fdsa_pkg.sv]
// Package for the Forth data stack and ALU: sizes, operation and status codes,
// beat structs and controller state type. Depends on nothing.
`default_nettype none
package fdsa_pkg;

    localparam int StackDepth = 1024;
    localparam int AddrW      = $clog2(StackDepth);
    localparam int DepthW     = $clog2(StackDepth + 1);

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_DUP   = 4'd6,
        OP_DROP  = 4'd7,
        OP_SWAP  = 4'd8,
        OP_OVER  = 4'd9,
        OP_ROT   = 4'd10,
        OP_SQRT  = 4'd11,
        OP_ABS   = 4'd12,
        OP_NEG   = 4'd13,
        OP_PRINT = 4'd14,
        OP_NOP   = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OVER  = 3'd1,
        ST_UNDER = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_SHORT = 3'd4
    } t_status;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic               printed_valid;
        logic signed [31:0] printed_value;
        logic [10:0]        depth;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_EXEC,
        S_MUL,
        S_ITER,
        S_FIN,
        S_WR1,
        S_WR2,
        S_WR3,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

[rtl/core/forth_data_stack_alu_top.sv]
// Top level of the Forth data stack and ALU; uses fdsa_pkg and fdsa_ram.
// One operation per beat, with the stack held in a single synchronous RAM.
// Div, mod and a non-negative sqrt run in one shared shift-subtract unit that retires one
// quotient or root bit per cycle.
// Throughput: one operation at a time; the next beat is taken the cycle after the result
// register is loaded (it may still wait for the consumer while a new beat runs).
// Reset (synchronous, active low) clears depth and control; stack RAM is not
// cleared since entries at or above the depth are never used.
`default_nettype none
module forth_data_stack_alu_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  fdsa_pkg::t_in_beat    i_data,
    output logic                        o_valid,
    input  wire                         i_ready,
    output fdsa_pkg::t_out_beat         o_data
);
    localparam int AW = fdsa_pkg::AddrW;
    localparam int DW = fdsa_pkg::DepthW;

    fdsa_pkg::t_state r_state, n_state;
    logic [DW-1:0]    r_depth, n_depth;
    logic [3:0]       r_op, n_op;
    logic [31:0]      r_lit, n_lit;
    // Operands: r_a is deeper, r_b is top; r_c is third for rot.
    logic [31:0]      r_a, n_a, r_b, n_b, r_c, n_c;
    logic [2:0]       r_status, n_status;
    logic [31:0]      r_res, n_res;
    // Shift-subtract unit: remainder, quotient/root, divisor, count.
    logic [65:0]      r_rem, n_rem;
    logic [63:0]      r_num, n_num;
    logic [63:0]      r_quo, n_quo;
    logic [32:0]      r_dvs, n_dvs;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic signed [63:0] r_prod, n_prod;
    logic             r_ov, n_ov;
    fdsa_pkg::t_out_beat r_out, n_out;
    logic             r_ovld, n_ovld;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    fdsa_ram #(.Width(32), .Depth(fdsa_pkg::StackDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_valid = r_ovld;
    assign o_data  = r_out;
    assign o_ready = (r_state == fdsa_pkg::S_IDLE);

    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [DW-1:0] dm(input logic [DW-1:0] d, input int k);
        return d - DW'(k);
    endfunction

    logic signed [63:0] sa, sb;
    logic [65:0]        trial;
    logic [31:0]        ia, ib;
    logic [31:0]        mag_a, mag_b;
    logic [65:0]        rem_sh;

    always_comb begin
        n_state = r_state; n_depth = r_depth; n_op = r_op; n_lit = r_lit;
        n_a = r_a; n_b = r_b; n_c = r_c; n_status = r_status; n_res = r_res;
        n_rem = r_rem; n_num = r_num; n_quo = r_quo; n_dvs = r_dvs; n_cnt = r_cnt;
        n_neg = r_neg; n_prod = r_prod; n_ov = r_ov; n_out = r_out;
        n_ovld = r_ovld && !i_ready;
        we = 1'b0; waddr = '0; wdata = r_res; raddr = '0;
        sa = 64'(signed'(r_a)); sb = 64'(signed'(r_b));
        ia = 32'(signed'(r_a) / 32'sd65536);
        ib = 32'(signed'(r_b) / 32'sd65536);
        mag_a = '0; mag_b = '0;
        rem_sh = '0; trial = '0;
        unique case (r_state)
            fdsa_pkg::S_IDLE: begin
                raddr = AW'(r_depth - 1'b1);
                if (i_valid && o_ready) begin
                    n_op = i_data.action; n_lit = i_data.value;
                    n_status = fdsa_pkg::ST_OK;
                    n_state = fdsa_pkg::S_RD1;
                end
            end
            fdsa_pkg::S_RD1: begin
                // Top's read was issued in IDLE; capture it and fetch the second entry.
                n_b = rdata;
                raddr = AW'(dm(r_depth, 2));
                n_state = fdsa_pkg::S_RD2;
            end
            fdsa_pkg::S_RD2: begin
                n_a = rdata;
                raddr = AW'(dm(r_depth, 3));
                n_state = fdsa_pkg::S_RD3;
            end
            fdsa_pkg::S_RD3: begin
                n_c = rdata;
                n_state = fdsa_pkg::S_EXEC;
            end
            fdsa_pkg::S_EXEC: begin
                n_state = fdsa_pkg::S_OUT;
                case (r_op)
                    fdsa_pkg::OP_PUSH: begin
                        n_res = r_lit; n_state = fdsa_pkg::S_WR1;
                    end
                    fdsa_pkg::OP_ADD, fdsa_pkg::OP_SUB, fdsa_pkg::OP_MUL,
                    fdsa_pkg::OP_DIV, fdsa_pkg::OP_MOD: begin
                        if (r_depth < DW'(2)) begin
                            n_status = fdsa_pkg::ST_UNDER; n_depth = '0;
                        end else begin
                            n_depth = dm(r_depth, 2);
                            n_state = fdsa_pkg::S_WR1;
                            if (r_op == fdsa_pkg::OP_ADD) begin
                                n_res = sat64(sa + sb);
                            end else if (r_op == fdsa_pkg::OP_SUB) begin
                                n_res = sat64(sa - sb);
                            end else if (r_op == fdsa_pkg::OP_MUL) begin
                                n_prod = 64'(signed'(r_a)) * 64'(signed'(r_b));
                                n_state = fdsa_pkg::S_MUL;
                            end else begin
                                if (r_op == fdsa_pkg::OP_DIV) begin
                                    mag_a = r_a[31] ? -r_a : r_a;
                                    mag_b = r_b[31] ? -r_b : r_b;
                                    n_num = {mag_a, 32'd0} >> 16;
                                    n_neg = r_a[31] ^ r_b[31];
                                    n_ov = (r_b == '0);
                                end else begin
                                    mag_a = ia[31] ? -ia : ia;
                                    mag_b = ib[31] ? -ib : ib;
                                    n_num = {mag_a, 32'd0};
                                    n_neg = ia[31];
                                    n_ov = (ib == '0);
                                end
                                n_dvs = {1'b0, mag_b};
                                n_rem = '0; n_quo = '0;
                                n_cnt = (r_op == fdsa_pkg::OP_DIV) ? 7'd48 : 7'd32;
                                if (r_op == fdsa_pkg::OP_DIV) begin
                                    n_num = {16'd0, mag_a, 16'd0};
                                    n_num = n_num << 16;
                                end
                                if (n_ov) begin
                                    n_status = fdsa_pkg::ST_DIVZ;
                                    n_state = fdsa_pkg::S_OUT;
                                end else begin
                                    n_state = fdsa_pkg::S_ITER;
                                end
                            end
                        end
                    end
                    fdsa_pkg::OP_DUP: begin
                        if (r_depth == '0) begin
                            n_status = fdsa_pkg::ST_UNDER;
                        end else begin
                            n_res = r_b; n_state = fdsa_pkg::S_WR1;
                        end
                    end
                    fdsa_pkg::OP_DROP: begin
                        if (r_depth == '0) n_status = fdsa_pkg::ST_UNDER;
                        else n_depth = dm(r_depth, 1);
                    end
                    fdsa_pkg::OP_SWAP: begin
                        if (r_depth < DW'(2)) begin
                            n_status = fdsa_pkg::ST_UNDER; n_depth = '0;
                        end else begin
                            n_state = fdsa_pkg::S_WR1;
                        end
                    end
                    fdsa_pkg::OP_OVER: begin
                        if (r_depth < DW'(2)) begin
                            n_status = fdsa_pkg::ST_SHORT;
                        end else begin
                            n_res = r_a; n_state = fdsa_pkg::S_WR1;
                        end
                    end
                    fdsa_pkg::OP_ROT: begin
                        if (r_depth < DW'(3)) n_status = fdsa_pkg::ST_SHORT;
                        else n_state = fdsa_pkg::S_WR1;
                    end
                    fdsa_pkg::OP_SQRT: begin
                        if (r_depth == '0) begin
                            n_status = fdsa_pkg::ST_UNDER;
                        end else begin
                            n_depth = dm(r_depth, 1);
                            if (r_b[31]) begin
                                n_res = '0; n_state = fdsa_pkg::S_WR1;
                            end else begin
                                // Radicand b<<16 fits 47 bits; root fits 24.
                                n_num = {r_b, 32'd0} >> 16;
                                n_num = n_num << 16;
                                n_rem = '0; n_quo = '0; n_cnt = 7'd24;
                                n_state = fdsa_pkg::S_ITER;
                            end
                        end
                    end
                    fdsa_pkg::OP_ABS, fdsa_pkg::OP_NEG: begin
                        if (r_depth == '0) begin
                            n_status = fdsa_pkg::ST_UNDER;
                        end else begin
                            n_depth = dm(r_depth, 1);
                            if (r_op == fdsa_pkg::OP_NEG || r_b[31]) n_res = sat64(-sb);
                            else n_res = r_b;
                            n_state = fdsa_pkg::S_WR1;
                        end
                    end
                    fdsa_pkg::OP_PRINT: begin
                        if (r_depth == '0) n_status = fdsa_pkg::ST_UNDER;
                        else n_depth = dm(r_depth, 1);
                    end
                    default: ;
                endcase
            end
            fdsa_pkg::S_MUL: begin
                n_res = sat64(r_prod / 64'sd65536);
                n_state = fdsa_pkg::S_WR1;
            end
            fdsa_pkg::S_ITER: begin
                if (r_op == fdsa_pkg::OP_SQRT) begin
                    // Two radicand bits per step; trial = 4*rem... vs 4q+1.
                    rem_sh = {r_rem[63:0], r_num[63:62]};
                    trial = rem_sh - {r_quo[63:0], 2'b01};
                    n_num = r_num << 2;
                    if (!trial[65]) begin
                        n_rem = trial; n_quo = {r_quo[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh; n_quo = {r_quo[62:0], 1'b0};
                    end
                end else begin
                    rem_sh = {r_rem[64:0], r_num[63]};
                    trial = rem_sh - {33'd0, r_dvs};
                    n_num = r_num << 1;
                    if (!trial[65]) begin
                        n_rem = trial; n_quo = {r_quo[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh; n_quo = {r_quo[62:0], 1'b0};
                    end
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) n_state = fdsa_pkg::S_FIN;
            end
            fdsa_pkg::S_FIN: begin
                if (r_op == fdsa_pkg::OP_SQRT) begin
                    n_res = r_quo[31:0];
                end else if (r_op == fdsa_pkg::OP_DIV) begin
                    n_res = sat64(r_neg ? -signed'(r_quo) : signed'(r_quo));
                end else begin
                    n_res = r_neg ? -(r_rem[31:0] << 16) : (r_rem[31:0] << 16);
                end
                n_state = fdsa_pkg::S_WR1;
            end
            fdsa_pkg::S_WR1: begin
                n_state = fdsa_pkg::S_OUT;
                if (r_op == fdsa_pkg::OP_SWAP) begin
                    we = 1'b1; waddr = AW'(dm(r_depth, 2)); wdata = r_b;
                    n_state = fdsa_pkg::S_WR2;
                end else if (r_op == fdsa_pkg::OP_ROT) begin
                    we = 1'b1; waddr = AW'(dm(r_depth, 3)); wdata = r_a;
                    n_state = fdsa_pkg::S_WR2;
                end else if (r_depth >= DW'(fdsa_pkg::StackDepth)) begin
                    n_status = fdsa_pkg::ST_OVER;
                end else begin
                    we = 1'b1; waddr = AW'(r_depth); wdata = r_res;
                    n_depth = r_depth + 1'b1;
                end
            end
            fdsa_pkg::S_WR2: begin
                we = 1'b1; waddr = AW'(dm(r_depth, r_op == fdsa_pkg::OP_ROT ? 2 : 1));
                wdata = (r_op == fdsa_pkg::OP_ROT) ? r_b : r_a;
                n_state = (r_op == fdsa_pkg::OP_ROT) ? fdsa_pkg::S_WR3 : fdsa_pkg::S_OUT;
            end
            fdsa_pkg::S_WR3: begin
                we = 1'b1; waddr = AW'(dm(r_depth, 1)); wdata = r_c;
                n_state = fdsa_pkg::S_OUT;
            end
            fdsa_pkg::S_OUT: begin
                if (!r_ovld || i_ready) begin
                    n_out.status = r_status;
                    n_out.printed_valid = (r_op == fdsa_pkg::OP_PRINT) &&
                                          (r_status == fdsa_pkg::ST_OK);
                    n_out.printed_value = n_out.printed_valid ? r_b : '0;
                    n_out.depth = 11'(r_depth);
                    n_ovld = 1'b1;
                    n_state = fdsa_pkg::S_IDLE;
                end
            end
            default: n_state = fdsa_pkg::S_IDLE;
        endcase
    end

    // The read issued in RD1 fetches depth-2, captured as r_a in RD2; the read
    // issued in RD2 fetches depth-3, the third entry for rot, captured as r_c in RD3.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdsa_pkg::S_IDLE;
            r_depth <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_ovld  <= n_ovld;
        end
        r_op <= n_op; r_lit <= n_lit; r_a <= n_a; r_b <= n_b; r_c <= n_c;
        r_status <= n_status; r_res <= n_res; r_rem <= n_rem; r_num <= n_num;
        r_quo <= n_quo; r_dvs <= n_dvs; r_cnt <= n_cnt; r_neg <= n_neg;
        r_prod <= n_prod; r_ov <= n_ov; r_out <= n_out;
    end

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(fdsa_pkg::StackDepth))
        else $error("stack depth beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result beat changed while stalled");
    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.printed_valid) |-> (o_data.printed_value == '0))
        else $error("printed value not zero");
    a_depth_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdsa_pkg::S_IDLE && !(i_valid && o_ready)) |=> $stable(r_depth))
        else $error("depth changed while idle");
endmodule
`default_nettype wire

[rtl/core/fdsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module fdsa_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
